>>> design/nlsl_pkg.sv
// ----------------------------------------------------------------------------
// nlsl_pkg: shared types and constants
// Word formats, command codes, register map and controller interface types
// for the nearest light-sample lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlsl_pkg;

  // Table size default and faces per sample
  localparam int MaxSamplesDef = 64;
  localparam int Faces         = 6;

  // APB address width: four 32-bit registers
  localparam int ApbAw = 4;

  // Input command codes
  localparam logic [1:0] CMD_POS   = 2'd0;
  localparam logic [1:0] CMD_COLOR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_IN_USE = 2'd0;
  localparam logic [1:0] REG_RED    = 2'd1;
  localparam logic [1:0] REG_GREEN  = 2'd2;
  localparam logic [1:0] REG_BLUE   = 2'd3;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [5:0]  sample_index;
    logic        [2:0]  face;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [15:0] color_red;
    logic        [15:0] color_green;
    logic        [15:0] color_blue;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_face;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        out_last;
    logic        out_empty;
  } out_word_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } color_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_POS,
    ST_WR_COL,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_EMIT
  } nlsl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture input word
    logic scan_clear;  // start a query: clear counters and best
    logic wr_pos;      // position write with default colors
    logic wr_col;      // single face color write
    logic scan_issue;  // read next sample position
    logic fetch;       // read colors of best sample
    logic emit;        // load output register with next face
  } nlsl_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;       // no samples in use
    logic scan_last;   // current scan address is the last one
    logic pipe_busy;   // distance pipeline still holds samples
    logic out_free;    // output register can take a word
    logic face_last;   // face counter at the sixth face
  } nlsl_sts_t;

endpackage

>>> design/nlsl_ctrl.sv
// ----------------------------------------------------------------------------
// nlsl_ctrl: command sequencer
// Accepts one input word at a time and steps the datapath through writes,
// the distance scan, the color fetch and the six-word emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  output logic                in_stall_o,
  input  nlsl_pkg::nlsl_sts_t sts_i,
  output nlsl_pkg::nlsl_ctl_t ctl_o
);

  nlsl_pkg::nlsl_state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && (state_q == nlsl_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nlsl_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            nlsl_pkg::CMD_POS:   state_d = nlsl_pkg::ST_WR_POS;
            nlsl_pkg::CMD_COLOR: state_d = nlsl_pkg::ST_WR_COL;
            nlsl_pkg::CMD_QUERY: state_d = sts_i.empty ? nlsl_pkg::ST_EMIT
                                                       : nlsl_pkg::ST_SCAN;
            default:             state_d = nlsl_pkg::ST_IDLE;
          endcase
        end
      end
      nlsl_pkg::ST_WR_POS: state_d = nlsl_pkg::ST_IDLE;
      nlsl_pkg::ST_WR_COL: state_d = nlsl_pkg::ST_IDLE;
      nlsl_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = nlsl_pkg::ST_DRAIN;
      end
      nlsl_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = nlsl_pkg::ST_FETCH;
      end
      nlsl_pkg::ST_FETCH: state_d = nlsl_pkg::ST_EMIT;
      nlsl_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.face_last) state_d = nlsl_pkg::ST_IDLE;
      end
      default: state_d = nlsl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o      = '0;
    in_stall_o = (state_q != nlsl_pkg::ST_IDLE);
    unique case (state_q)
      nlsl_pkg::ST_IDLE: begin
        ctl_o.load       = accept;
        ctl_o.scan_clear = accept && (in_cmd_i == nlsl_pkg::CMD_QUERY);
      end
      nlsl_pkg::ST_WR_POS: ctl_o.wr_pos     = 1'b1;
      nlsl_pkg::ST_WR_COL: ctl_o.wr_col     = 1'b1;
      nlsl_pkg::ST_SCAN:   ctl_o.scan_issue = 1'b1;
      nlsl_pkg::ST_DRAIN:  ctl_o            = '0;
      nlsl_pkg::ST_FETCH:  ctl_o.fetch      = 1'b1;
      nlsl_pkg::ST_EMIT:   ctl_o.emit       = sts_i.out_free;
      default:             ctl_o            = '0;
    endcase
  end

endmodule

>>> design/nlsl_datapath.sv
// ----------------------------------------------------------------------------
// nlsl_datapath: sample tables, distance pipeline and output register
// Holds positions and per-face colors, streams positions through a
// four-stage squared-distance pipeline and keeps the running best.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlsl_datapath #(
  parameter int MAX_SAMPLES = nlsl_pkg::MaxSamplesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nlsl_pkg::nlsl_ctl_t  ctl_i,
  output nlsl_pkg::nlsl_sts_t  sts_o,
  input  nlsl_pkg::in_word_t   in_word_i,
  input  logic [6:0]           samples_in_use_i,
  input  nlsl_pkg::color_t     dflt_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output nlsl_pkg::out_word_t  out_word_o
);

  localparam int IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CntW = $clog2(MAX_SAMPLES + 1);

  // Tables
  nlsl_pkg::pos_t   pos_mem [MAX_SAMPLES];
  nlsl_pkg::color_t col_mem [nlsl_pkg::Faces][MAX_SAMPLES];

  nlsl_pkg::in_word_t  item_q;
  nlsl_pkg::out_word_t out_q;
  nlsl_pkg::color_t    col_rd_q [nlsl_pkg::Faces];
  nlsl_pkg::pos_t      pos_rd_q;

  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] addr_q, wr_addr;
  logic [IdxW-1:0] rd_idx_q, dif_idx_q, sq_idx_q, sum_idx_q, best_idx_q;
  logic [2:0]      face_q;
  logic            empty_q, out_valid_q, best_v_q;
  logic            rd_v_q, dif_v_q, sq_v_q, sum_v_q;
  logic            wr_ok, face_ok, upd, out_free;
  logic [16:0]     dx, dy, dz;
  logic [15:0]     ax_q, ay_q, az_q;
  logic [31:0]     sx_q, sy_q, sz_q;
  logic [33:0]     sum_q, best_d_q;

  // Search count saturated at the table size
  assign cnt = (32'(samples_in_use_i) > MAX_SAMPLES) ? CntW'(MAX_SAMPLES)
                                                       : CntW'(samples_in_use_i);

  assign wr_ok   = 32'(item_q.sample_index) < MAX_SAMPLES;
  assign face_ok = item_q.face < 3'(nlsl_pkg::Faces);
  assign wr_addr = IdxW'(item_q.sample_index);

  // Coordinate differences, 17-bit two's complement
  assign dx = {pos_rd_q.x[15], pos_rd_q.x} - {item_q.pos_x[15], item_q.pos_x};
  assign dy = {pos_rd_q.y[15], pos_rd_q.y} - {item_q.pos_y[15], item_q.pos_y};
  assign dz = {pos_rd_q.z[15], pos_rd_q.z} - {item_q.pos_z[15], item_q.pos_z};

  // Strictly smaller wins, so ties keep the lower index
  assign upd = sum_v_q && (!best_v_q || (sum_q < best_d_q));

  assign out_free = !out_valid_q || !out_stall_i;

  // Status
  always_comb begin
    sts_o.empty     = (cnt == '0);
    sts_o.scan_last = (32'(addr_q) + 32'd1) == 32'(cnt);
    sts_o.pipe_busy = rd_v_q || dif_v_q || sq_v_q || sum_v_q;
    sts_o.out_free  = out_free;
    sts_o.face_last = (face_q == 3'(nlsl_pkg::Faces - 1));
  end

  // Table writes and reads
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_pos && wr_ok) begin
      pos_mem[wr_addr] <= '{x: item_q.pos_x, y: item_q.pos_y, z: item_q.pos_z};
    end
    for (int f = 0; f < nlsl_pkg::Faces; f++) begin
      if (ctl_i.wr_pos && wr_ok) begin
        col_mem[f][wr_addr] <= dflt_i;
      end else if (ctl_i.wr_col && wr_ok && face_ok && (item_q.face == 3'(f))) begin
        col_mem[f][wr_addr] <= '{red:   item_q.color_red,
                                 green: item_q.color_green,
                                 blue:  item_q.color_blue};
      end
    end
    if (ctl_i.scan_issue) begin
      pos_rd_q <= pos_mem[addr_q];
    end
    if (ctl_i.fetch) begin
      for (int f = 0; f < nlsl_pkg::Faces; f++) begin
        col_rd_q[f] <= col_mem[f][best_idx_q];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      face_q      <= '0;
      empty_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      dif_v_q     <= 1'b0;
      sq_v_q      <= 1'b0;
      sum_v_q     <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q  <= ctl_i.scan_issue;
      dif_v_q <= rd_v_q;
      sq_v_q  <= dif_v_q;
      sum_v_q <= sq_v_q;
      if (ctl_i.scan_clear) begin
        addr_q   <= '0;
        face_q   <= '0;
        empty_q  <= (cnt == '0);
        best_v_q <= 1'b0;
      end else begin
        if (ctl_i.scan_issue) addr_q <= addr_q + IdxW'(1);
        if (ctl_i.emit) face_q <= face_q + 3'd1;
        if (upd) best_v_q <= 1'b1;
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: item, distance pipeline, best, output word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) item_q <= in_word_i;
    rd_idx_q  <= addr_q;
    ax_q      <= dx[16] ? 16'(-dx) : 16'(dx);
    ay_q      <= dy[16] ? 16'(-dy) : 16'(dy);
    az_q      <= dz[16] ? 16'(-dz) : 16'(dz);
    dif_idx_q <= rd_idx_q;
    sx_q      <= 32'(ax_q) * 32'(ax_q);
    sy_q      <= 32'(ay_q) * 32'(ay_q);
    sz_q      <= 32'(az_q) * 32'(az_q);
    sq_idx_q  <= dif_idx_q;
    sum_q     <= 34'(sx_q) + 34'(sy_q) + 34'(sz_q);
    sum_idx_q <= sq_idx_q;
    if (upd) begin
      best_d_q   <= sum_q;
      best_idx_q <= sum_idx_q;
    end
    if (ctl_i.emit) begin
      out_q.out_face  <= face_q;
      out_q.out_red   <= empty_q ? 16'd0 : col_rd_q[face_q].red;
      out_q.out_green <= empty_q ? 16'd0 : col_rd_q[face_q].green;
      out_q.out_blue  <= empty_q ? 16'd0 : col_rd_q[face_q].blue;
      out_q.out_last  <= (face_q == 3'(nlsl_pkg::Faces - 1));
      out_q.out_empty <= empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // A word is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> out_free)
    else $error("emit while output register busy");

  // Scan never reads past the samples in use
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scan_issue |-> (32'(addr_q) < 32'(cnt)))
    else $error("scan address beyond count");

  // Last flag marks exactly the sixth face
  a_last_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.out_last == (out_q.out_face == 3'(nlsl_pkg::Faces - 1))))
    else $error("last flag on wrong face");

  // A fetch follows a completed scan with a valid best
  a_fetch_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fetch |-> (best_v_q && !sum_v_q && !rd_v_q))
    else $error("fetch without a settled best sample");
`endif

endmodule

>>> design/nearest_light_sample_lookup_core.sv
// ----------------------------------------------------------------------------
// nearest_light_sample_lookup_core: nearest light-sample lookup, top level
// Sample table with position and face color writes and a nearest-sample
// query by squared distance, with an APB register port.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               word
//   in       input      in_valid_i / in_stall_o  in_word_t
//   out      output     out_valid_o / out_stall_i out_word_t
//   cfg      APB slave  psel, penable, pready    32-bit registers at 4*i
//
//   Position or color write: the accept is followed by the write state, after
//   which the controller is idle again. Query: the scan reads one sample
//   per cycle from the position table for N = samples searched (min of
//   samples_in_use and MAX_SAMPLES), then the pipeline drains, the best
//   sample's colors are fetched and six words are emitted; an empty
//   query goes straight to the emit. Output stalls pause the six-word emit.
//   Reset clears the control and APB registers; table contents are undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_light_sample_lookup_core #(
  parameter int MAX_SAMPLES = nlsl_pkg::MaxSamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nlsl_pkg::in_word_t            in_word_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nlsl_pkg::out_word_t           out_word_o,
  // APB
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlsl_pkg::ApbAw-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [6:0]          in_use_q;
  nlsl_pkg::color_t    dflt_q;
  nlsl_pkg::nlsl_ctl_t ctl;
  nlsl_pkg::nlsl_sts_t sts;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      dflt_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        nlsl_pkg::REG_IN_USE: in_use_q     <= pwdata[6:0];
        nlsl_pkg::REG_RED:    dflt_q.red   <= pwdata[15:0];
        nlsl_pkg::REG_GREEN:  dflt_q.green <= pwdata[15:0];
        nlsl_pkg::REG_BLUE:   dflt_q.blue  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (paddr[3:2])
      nlsl_pkg::REG_IN_USE: prdata = 32'(in_use_q);
      nlsl_pkg::REG_RED:    prdata = 32'(dflt_q.red);
      nlsl_pkg::REG_GREEN:  prdata = 32'(dflt_q.green);
      nlsl_pkg::REG_BLUE:   prdata = 32'(dflt_q.blue);
      default:              prdata = '0;
    endcase
  end

  nlsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_word_i.command),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  nlsl_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .in_word_i        (in_word_i),
    .samples_in_use_i (in_use_q),
    .dflt_i           (dflt_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_word_o       (out_word_o)
  );

endmodule

>>> test/tb_nearest_light_sample_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_light_sample_lookup_core: self-checking testbench
// Drives sample position writes, face color writes and nearest-sample queries
// through the valid/stall input channel and programs the registers over APB.
// The local sample table copy, or a directed row's colors, predicts the six
// face words of every query; each is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_light_sample_lookup_core;

  localparam int unsigned CycleLimit    = 400000;
  localparam int          SettleCycles  = 20;
  localparam int          WordsPerPhase = 30;
  localparam int          RandPhases    = 7;

  // One step of the directed part: a register write or an input word
  typedef struct {
    logic                 is_cfg;
    logic [1:0]           reg_idx;
    logic [31:0]          reg_val;
    nlsl_pkg::in_word_t   word;
    logic                 typed;        // expected faces given in the row
    nlsl_pkg::color_t     typed_col;
    logic                 typed_empty;
  } stim_row_t;

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall_o;
  nlsl_pkg::in_word_t            in_word   = '0;
  logic                          out_valid_o;
  logic                          out_stall = 1'b1;
  nlsl_pkg::out_word_t           out_word_o;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [nlsl_pkg::ApbAw-1:0]    paddr     = '0;
  logic [31:0]                   pwdata    = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Local copy of the sample table and registers
  nlsl_pkg::pos_t        probe_pos [nlsl_pkg::MaxSamplesDef];
  nlsl_pkg::color_t      probe_col [nlsl_pkg::MaxSamplesDef][nlsl_pkg::Faces];
  logic [6:0]            in_use_reg;
  nlsl_pkg::color_t      dflt_col;

  nlsl_pkg::out_word_t   due_faces[$];
  nlsl_pkg::out_word_t   want;
  stim_row_t             plan[$];
  int                    idle_pct     = 38;
  int                    mismatches   = 0;
  int                    words_sent   = 0;
  int                    queries_sent = 0;
  int                    faces_seen   = 0;
  int unsigned           cycles       = 0;

  nearest_light_sample_lookup_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Append one expected result word
  task automatic queue_face(input nlsl_pkg::out_word_t o);
    due_faces = {due_faces, o};
  endtask

  // Append one directed row
  task automatic add_row(input stim_row_t r);
    plan = {plan, r};
  endtask

  // Apply one input word to the local table; queries queue six face words
  task automatic apply_probe_command(input nlsl_pkg::in_word_t w);
    int unsigned         n, best, i, f;
    longint              dx, dy, dz, sq_dist, best_dist;
    nlsl_pkg::out_word_t o;
    case (w.command)
      nlsl_pkg::CMD_POS: begin
        probe_pos[w.sample_index] = {w.pos_x, w.pos_y, w.pos_z};
        for (f = 0; f < nlsl_pkg::Faces; f++) probe_col[w.sample_index][f] = dflt_col;
      end
      nlsl_pkg::CMD_COLOR: begin
        if (w.face < nlsl_pkg::Faces)
          probe_col[w.sample_index][w.face] = {w.color_red, w.color_green, w.color_blue};
      end
      nlsl_pkg::CMD_QUERY: begin
        queries_sent++;
        n = (in_use_reg > nlsl_pkg::MaxSamplesDef) ? nlsl_pkg::MaxSamplesDef : in_use_reg;
        best = 0;
        best_dist = 0;
        // strict less-than keeps the lowest index on a tie
        for (i = 0; i < n; i++) begin
          dx = longint'($signed(probe_pos[i].x)) - longint'($signed(w.pos_x));
          dy = longint'($signed(probe_pos[i].y)) - longint'($signed(w.pos_y));
          dz = longint'($signed(probe_pos[i].z)) - longint'($signed(w.pos_z));
          sq_dist = dx * dx + dy * dy + dz * dz;
          if (i == 0 || sq_dist < best_dist) begin
            best_dist = sq_dist;
            best = i;
          end
        end
        for (f = 0; f < nlsl_pkg::Faces; f++) begin
          o.out_face  = 3'(f);
          o.out_red   = (n == 0) ? 16'h0 : probe_col[best][f].red;
          o.out_green = (n == 0) ? 16'h0 : probe_col[best][f].green;
          o.out_blue  = (n == 0) ? 16'h0 : probe_col[best][f].blue;
          o.out_last  = (f == nlsl_pkg::Faces - 1);
          o.out_empty = (n == 0);
          queue_face(o);
        end
      end
      default: ;
    endcase
  endtask

  // Present one word, hold it until accepted, then record what it causes
  task automatic send_word(input nlsl_pkg::in_word_t w, input logic typed,
                           input nlsl_pkg::color_t tcol, input logic tempty);
    int                  f;
    nlsl_pkg::out_word_t o;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (typed) begin
      queries_sent++;
      for (f = 0; f < nlsl_pkg::Faces; f++) begin
        o.out_face  = 3'(f);
        o.out_red   = tcol.red;
        o.out_green = tcol.green;
        o.out_blue  = tcol.blue;
        o.out_last  = (f == nlsl_pkg::Faces - 1);
        o.out_empty = tempty;
        queue_face(o);
      end
    end else begin
      apply_probe_command(w);
    end
  endtask

  // Drain: wait for all queued faces, then let writes finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (due_faces.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB register write: setup, access, then idle with psel dropped
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      nlsl_pkg::REG_IN_USE: in_use_reg     = val[6:0];
      nlsl_pkg::REG_RED:    dflt_col.red   = val[15:0];
      nlsl_pkg::REG_GREEN:  dflt_col.green = val[15:0];
      nlsl_pkg::REG_BLUE:   dflt_col.blue  = val[15:0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t cmd_row(logic [1:0] cmd, int idx, int face, int x, int y,
                                        int z, int r, int g, int b);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.reg_idx     = nlsl_pkg::REG_IN_USE;
    row.reg_val     = '0;
    row.word        = {cmd, 6'(idx), 3'(face), 16'(x), 16'(y), 16'(z), 16'(r), 16'(g),
                       16'(b)};
    row.typed       = 1'b0;
    row.typed_col   = '0;
    row.typed_empty = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    stim_row_t row;
    row = cmd_row(nlsl_pkg::CMD_POS, 0, 0, 0, 0, 0, 0, 0, 0);
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic stim_row_t typed_query(int x, int y, int z, nlsl_pkg::color_t c,
                                            logic empty);
    stim_row_t row;
    row = cmd_row(nlsl_pkg::CMD_QUERY, 0, 0, x, y, z, 0, 0, 0);
    row.typed       = 1'b1;
    row.typed_col   = c;
    row.typed_empty = empty;
    return row;
  endfunction

  // Coordinate mix: full range, a small cluster around zero, or an extreme
  function automatic logic [15:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(3);
    if (pick < 2) return 16'($urandom);
    if (pick == 2) return 16'($urandom_range(6)) - 16'd3;
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'h0000;
    endcase
  endfunction

  // Random word: mostly meaningful commands, some ignored noise
  function automatic nlsl_pkg::in_word_t random_command();
    nlsl_pkg::in_word_t w;
    int unsigned        pick, src;
    w = {2'($urandom), 6'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    pick = $urandom_range(99);
    if (pick < 40) begin
      w.command = nlsl_pkg::CMD_QUERY;
      // aim near a stored sample most of the time
      if ($urandom_range(3) != 0) begin
        src = $urandom_range(nlsl_pkg::MaxSamplesDef - 1);
        w.pos_x = probe_pos[src].x + 16'($urandom_range(6)) - 16'd3;
        w.pos_y = probe_pos[src].y + 16'($urandom_range(6)) - 16'd3;
        w.pos_z = probe_pos[src].z + 16'($urandom_range(6)) - 16'd3;
      end else begin
        w.pos_x = random_coord();
        w.pos_y = random_coord();
        w.pos_z = random_coord();
      end
    end else if (pick < 65) begin
      w.command = nlsl_pkg::CMD_POS;
      // copy another sample's position now and then to force ties
      if ($urandom_range(3) == 0) begin
        src = $urandom_range(nlsl_pkg::MaxSamplesDef - 1);
        {w.pos_x, w.pos_y, w.pos_z} = probe_pos[src];
      end else begin
        w.pos_x = random_coord();
        w.pos_y = random_coord();
        w.pos_z = random_coord();
      end
    end else if (pick < 90) begin
      w.command = nlsl_pkg::CMD_COLOR;
      w.face    = 3'($urandom_range(nlsl_pkg::Faces - 1));
      if ($urandom_range(4) == 0) begin
        w.color_red   = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        w.color_green = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        w.color_blue  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
    end else if (pick < 95) begin
      w.command = nlsl_pkg::CMD_COLOR;
      w.face    = 3'($urandom_range(7, nlsl_pkg::Faces));
    end else begin
      w.command = 2'd3;
    end
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      mismatches++;
    end
  endtask

  // Result checker and random output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      faces_seen++;
      if (due_faces.size() == 0) begin
        $error("result word with nothing queued: %p", out_word_o);
        mismatches++;
      end else begin
        want = due_faces.pop_front();
        check_field("out_face",  want.out_face,  out_word_o.out_face);
        check_field("out_red",   want.out_red,   out_word_o.out_red);
        check_field("out_green", want.out_green, out_word_o.out_green);
        check_field("out_blue",  want.out_blue,  out_word_o.out_blue);
        check_field("out_last",  want.out_last,  out_word_o.out_last);
        check_field("out_empty", want.out_empty, out_word_o.out_empty);
      end
    end
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  initial begin
    nlsl_pkg::in_word_t w;
    stim_row_t          row;
    int                 i, ph, live;
    nlsl_pkg::color_t   c_first;

    for (i = 0; i < nlsl_pkg::MaxSamplesDef; i++) begin
      probe_pos[i] = '0;
      for (int f = 0; f < nlsl_pkg::Faces; f++) probe_col[i][f] = '0;
    end
    in_use_reg = '0;
    dflt_col   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, ties, ignored words
    c_first = {16'hFFFF, 16'h0000, 16'h8000};
    add_row(typed_query(0, 0, 0, '0, 1'b1));
    add_row(cfg_row(nlsl_pkg::REG_RED, 32'hFFFF));
    add_row(cfg_row(nlsl_pkg::REG_GREEN, 32'h0000));
    add_row(cfg_row(nlsl_pkg::REG_BLUE, 32'h8000));
    add_row(cmd_row(nlsl_pkg::CMD_POS, 0, 0, -32768, -32768, -32768, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_POS, 1, 0, 32767, 32767, 32767, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_POS, 2, 0, 0, 0, 0, 0, 0, 0));
    add_row(cfg_row(nlsl_pkg::REG_RED, 32'h1234));
    add_row(cfg_row(nlsl_pkg::REG_GREEN, 32'h00FF));
    add_row(cfg_row(nlsl_pkg::REG_BLUE, 32'hFF00));
    add_row(cmd_row(nlsl_pkg::CMD_POS, 3, 0, 0, 0, 0, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_COLOR, 3, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF));
    add_row(cmd_row(nlsl_pkg::CMD_COLOR, 1, 5, 0, 0, 0, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_COLOR, 1, 2, 0, 0, 0, 'h8000, 'h7FFF, 'h0001));
    add_row(cmd_row(nlsl_pkg::CMD_COLOR, 2, 6, 0, 0, 0, 1, 2, 3));
    add_row(cmd_row(nlsl_pkg::CMD_COLOR, 2, 7, 0, 0, 0, 4, 5, 6));
    add_row(cmd_row(2'd3, 2, 0, 5, 5, 5, 7, 8, 9));
    add_row(cfg_row(nlsl_pkg::REG_IN_USE, 32'd4));
    add_row(typed_query(-32768, -32768, -32768, c_first, 1'b0));
    add_row(cmd_row(nlsl_pkg::CMD_QUERY, 0, 0, 32767, 32767, 32767, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_QUERY, 0, 0, 1, -1, 0, 0, 0, 0));
    add_row(cmd_row(nlsl_pkg::CMD_QUERY, 0, 0, -32768, 32767, 0, 0, 0, 0));
    add_row(cfg_row(nlsl_pkg::REG_IN_USE, 32'd1));
    add_row(typed_query(32767, 32767, 32767, c_first, 1'b0));
    add_row(cfg_row(nlsl_pkg::REG_IN_USE, 32'd0));
    add_row(typed_query(100, -100, 7, '0, 1'b1));

    foreach (plan[k]) begin
      row = plan[k];
      if (row.is_cfg) begin
        settle();
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        send_word(row.word, row.typed, row.typed_col, row.typed_empty);
      end
    end

    // Fill every table entry in order, some with a face color right after
    settle();
    reg_write(nlsl_pkg::REG_RED, 32'($urandom_range(16'hFFFF)));
    reg_write(nlsl_pkg::REG_GREEN, 32'($urandom_range(16'hFFFF)));
    reg_write(nlsl_pkg::REG_BLUE, 32'($urandom_range(16'hFFFF)));
    for (i = 0; i < nlsl_pkg::MaxSamplesDef; i++) begin
      w = random_command();
      w.command      = nlsl_pkg::CMD_POS;
      w.sample_index = 6'(i);
      w.pos_x        = random_coord();
      w.pos_y        = random_coord();
      w.pos_z        = random_coord();
      send_word(w, 1'b0, '0, 1'b0);
      if ($urandom_range(9) < 3) begin
        w.command = nlsl_pkg::CMD_COLOR;
        w.face    = 3'($urandom_range(nlsl_pkg::Faces - 1));
        send_word(w, 1'b0, '0, 1'b0);
      end
    end

    // Random phases over several register settings; one runs without idling
    for (ph = 0; ph < RandPhases; ph++) begin
      settle();
      case (ph)
        0:       reg_write(nlsl_pkg::REG_IN_USE, 32'd64);
        1:       reg_write(nlsl_pkg::REG_IN_USE, 32'd127);
        2:       reg_write(nlsl_pkg::REG_IN_USE, 32'd0);
        3:       reg_write(nlsl_pkg::REG_IN_USE, 32'd1);
        default: reg_write(nlsl_pkg::REG_IN_USE,
                           32'($urandom_range(nlsl_pkg::MaxSamplesDef, 1)));
      endcase
      if (ph == 0) begin
        reg_write(nlsl_pkg::REG_RED, 32'hFFFF);
        reg_write(nlsl_pkg::REG_GREEN, 32'hFFFF);
        reg_write(nlsl_pkg::REG_BLUE, 32'hFFFF);
      end else if (ph == 2) begin
        reg_write(nlsl_pkg::REG_RED, 32'h0);
        reg_write(nlsl_pkg::REG_GREEN, 32'h0);
        reg_write(nlsl_pkg::REG_BLUE, 32'h0);
      end else begin
        reg_write(nlsl_pkg::REG_RED, 32'($urandom_range(16'hFFFF)));
        reg_write(nlsl_pkg::REG_GREEN, 32'($urandom_range(16'hFFFF)));
        reg_write(nlsl_pkg::REG_BLUE, 32'($urandom_range(16'hFFFF)));
      end
      idle_pct = (ph == 4) ? 0 : 38;
      live = 0;
      while (live < WordsPerPhase) begin
        w = random_command();
        if (w.command != 2'd3 &&
            !(w.command == nlsl_pkg::CMD_COLOR && w.face >= nlsl_pkg::Faces)) live++;
        send_word(w, 1'b0, '0, 1'b0);
      end
    end

    settle();
    $display("Sent %0d input words (%0d queries) across empty, partial, full and",
             words_sent, queries_sent);
    $display("saturated sample counts; %0d result words checked, %0d mismatches",
             faces_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
